// File: hdl/imufp_pkg.sv
// ----------------------------------------------------------------------------
// imufp_pkg
// Shared types and constants of the IMU frame parser: register indexes,
// reset values, frame class codes and the frame record handed between stages.
// ----------------------------------------------------------------------------
package imufp_pkg;

    localparam int unsigned ByteW     = 8;
    localparam int unsigned DataBytes = 9;
    localparam int unsigned CountW    = 4;
    localparam int unsigned CfgIdxW   = 8;

    localparam logic [ByteW-1:0] HEADER_RESET = 8'h55;
    localparam logic [ByteW-1:0] ACCEL_RESET  = 8'h51;
    localparam logic [ByteW-1:0] GYRO_RESET   = 8'h52;
    localparam logic [ByteW-1:0] ANGLE_RESET  = 8'h53;

    // checksum byte arrives once this many data bytes are stored
    localparam logic [CountW-1:0] CHECK_COUNT = CountW'(DataBytes);

    typedef enum logic [CfgIdxW-1:0] {
        REG_HEADER = 8'd0,
        REG_ACCEL  = 8'd1,
        REG_GYRO   = 8'd2,
        REG_ANGLE  = 8'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CLASS_ACCEL = 2'd0,
        CLASS_GYRO  = 2'd1,
        CLASS_ANGLE = 2'd2,
        CLASS_OTHER = 2'd3
    } frame_class_t;

    typedef struct packed {
        logic [ByteW-1:0]   frame_type;
        logic signed [15:0] first_value;
        logic signed [15:0] second_value;
        logic signed [15:0] third_value;
        logic signed [15:0] temperature_raw;
    } frame_t;

    typedef struct packed {
        logic              in_frame;
        logic              at_check;
        logic [CountW-1:0] count;
    } collect_status_t;

endpackage

// File: hdl/imufp_collect.sv
// ----------------------------------------------------------------------------
// imufp_collect
// Header hunt, byte collection and running checksum for one frame.
// Flags a good frame in the cycle its checksum word is accepted.
// ----------------------------------------------------------------------------
module imufp_collect (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        byte_accept,
    input  logic [imufp_pkg::ByteW-1:0] rx_byte,
    input  logic [imufp_pkg::ByteW-1:0] header_byte,
    output logic                        frame_hit,
    output imufp_pkg::frame_t           frame,
    output imufp_pkg::collect_status_t  status
);
    import imufp_pkg::*;

    logic              in_frame_reg, in_frame_next;
    logic [CountW-1:0] count_reg, count_next;
    logic [ByteW-1:0]  sum_reg, sum_next;
    logic [ByteW-1:0]  bytes_reg [DataBytes];
    logic              at_check;

    // a count of nine or more means this word is the checksum
    assign at_check = in_frame_reg && (count_reg >= CHECK_COUNT);

    always_comb begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        frame_hit     = 1'b0;
        if (byte_accept) begin
            if (!in_frame_reg) begin
                if (rx_byte == header_byte) begin
                    in_frame_next = 1'b1;
                    count_next    = '0;
                    sum_next      = header_byte;
                end
            end else if (at_check) begin
                in_frame_next = 1'b0;
                count_next    = '0;
                frame_hit     = (sum_reg == rx_byte);
            end else begin
                sum_next   = sum_reg + rx_byte;
                count_next = count_reg + CountW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
            sum_reg      <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
        end
    end

    // data store: each entry loads when the count points at it
    always_ff @(posedge aclk) begin
        for (int i = 0; i < DataBytes; i++) begin
            if (byte_accept && in_frame_reg && !at_check && (count_reg == CountW'(i))) begin
                bytes_reg[i] <= rx_byte;
            end
        end
    end

    assign frame.frame_type      = bytes_reg[0];
    assign frame.first_value     = {bytes_reg[2], bytes_reg[1]};
    assign frame.second_value    = {bytes_reg[4], bytes_reg[3]};
    assign frame.third_value     = {bytes_reg[6], bytes_reg[5]};
    assign frame.temperature_raw = {bytes_reg[8], bytes_reg[7]};

    assign status.in_frame = in_frame_reg;
    assign status.at_check = at_check;
    assign status.count    = count_reg;

endmodule

// File: hdl/imufp_out.sv
// ----------------------------------------------------------------------------
// imufp_out
// Frame classification and the result register of the output channel.
// ----------------------------------------------------------------------------
module imufp_out (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         frame_hit,
    input  imufp_pkg::frame_t            frame,
    input  logic [imufp_pkg::ByteW-1:0]  accel_type_code,
    input  logic [imufp_pkg::ByteW-1:0]  gyro_type_code,
    input  logic [imufp_pkg::ByteW-1:0]  angle_type_code,
    input  logic                         m_ready,
    output logic                         m_valid,
    output logic [imufp_pkg::ByteW-1:0]  m_frame_type,
    output logic [1:0]                   m_frame_class,
    output logic signed [15:0]           m_first_value,
    output logic signed [15:0]           m_second_value,
    output logic signed [15:0]           m_third_value,
    output logic signed [15:0]           m_temperature_raw
);
    import imufp_pkg::*;

    logic         valid_reg;
    frame_class_t class_next;
    frame_class_t class_reg;
    frame_t       frame_reg;

    // equal codes resolve by priority: accel, gyro, angle
    always_comb begin
        priority if (frame.frame_type == accel_type_code) begin
            class_next = CLASS_ACCEL;
        end else if (frame.frame_type == gyro_type_code) begin
            class_next = CLASS_GYRO;
        end else if (frame.frame_type == angle_type_code) begin
            class_next = CLASS_ANGLE;
        end else begin
            class_next = CLASS_OTHER;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (frame_hit) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_hit) begin
            frame_reg <= frame;
            class_reg <= class_next;
        end
    end

    assign m_valid           = valid_reg;
    assign m_frame_type      = frame_reg.frame_type;
    assign m_frame_class     = class_reg;
    assign m_first_value     = frame_reg.first_value;
    assign m_second_value    = frame_reg.second_value;
    assign m_third_value     = frame_reg.third_value;
    assign m_temperature_raw = frame_reg.temperature_raw;

endmodule

// File: hdl/imu_frame_parser.sv
// ----------------------------------------------------------------------------
// imu_frame_parser
// Byte-serial parser for 11-byte sensor frames with an 8-bit sum checksum.
// ----------------------------------------------------------------------------
// Takes one received word per cycle unless stalled. After the header byte it
// stores a type byte and eight payload bytes and keeps a running sum; the
// eleventh byte is compared with that sum, and a good frame appears on the
// result channel in the cycle after its checksum word is accepted, with its
// class, three signed little-endian values and the raw temperature. Bad frames
// are dropped silently. The only stall is a checksum word arriving while the
// result register still holds a frame the sink has not taken. The user must
// write cfg port registers only while idle; the block does not enforce it.
module imu_frame_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [imufp_pkg::CfgIdxW-1:0] cfg_index,
    input  logic [imufp_pkg::ByteW-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [imufp_pkg::ByteW-1:0]   s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [imufp_pkg::ByteW-1:0]   m_frame_type,
    output logic [1:0]                    m_frame_class,
    output logic signed [15:0]            m_first_value,
    output logic signed [15:0]            m_second_value,
    output logic signed [15:0]            m_third_value,
    output logic signed [15:0]            m_temperature_raw
);
    import imufp_pkg::*;

    logic [ByteW-1:0] header_reg;
    logic [ByteW-1:0] accel_reg;
    logic [ByteW-1:0] gyro_reg;
    logic [ByteW-1:0] angle_reg;

    logic            byte_accept;
    logic            frame_hit;
    frame_t          frame;
    collect_status_t status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg <= HEADER_RESET;
            accel_reg  <= ACCEL_RESET;
            gyro_reg   <= GYRO_RESET;
            angle_reg  <= ANGLE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_HEADER: header_reg <= cfg_wr_data;
                REG_ACCEL:  accel_reg  <= cfg_wr_data;
                REG_GYRO:   gyro_reg   <= cfg_wr_data;
                REG_ANGLE:  angle_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // only a checksum word can produce a result, so only it waits on the sink
    assign s_ready     = !status.at_check || !m_valid || m_ready;
    assign byte_accept = s_valid && s_ready;

    imufp_collect u_collect (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_rx_byte),
        .header_byte (header_reg),
        .frame_hit   (frame_hit),
        .frame       (frame),
        .status      (status)
    );

    imufp_out u_out (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .frame_hit         (frame_hit),
        .frame             (frame),
        .accel_type_code   (accel_reg),
        .gyro_type_code    (gyro_reg),
        .angle_type_code   (angle_reg),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_frame_type      (m_frame_type),
        .m_frame_class     (m_frame_class),
        .m_first_value     (m_first_value),
        .m_second_value    (m_second_value),
        .m_third_value     (m_third_value),
        .m_temperature_raw (m_temperature_raw)
    );

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        status.count <= CHECK_COUNT)
        else $error("byte count beyond checksum position");

    a_hunt_count: assert property (@(posedge aclk) disable iff (!aresetn)
        !status.in_frame |-> status.count == '0)
        else $error("byte count not cleared while hunting");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(byte_accept && status.at_check))
        else $error("result without an accepted checksum word");

    a_frame_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_accept && status.at_check |=> !status.in_frame)
        else $error("frame not closed after checksum word");

endmodule
